// ===== rtl/kpscan_pkg.sv =====
package kpscan_pkg;

  localparam int unsigned NumRows    = 4;
  localparam int unsigned NumCols    = 4;
  localparam int unsigned RowW       = 2;
  localparam int unsigned ColW       = 2;
  localparam int unsigned CodeW      = 8;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned CountW     = 8;
  localparam int unsigned MapW       = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 56;

  localparam logic [NumCols-1:0] AllHigh   = 4'hF;
  localparam logic [CodeW-1:0]   CodeZero  = 8'd48;
  localparam logic [CodeW-1:0]   CodeNine  = 8'd57;
  localparam logic [CountW-1:0]  CountMax  = 8'd255;

  // Reciprocal of ten: floor(x * RecipTen / 2^35) == x / 10 for any 32-bit x
  localparam logic [31:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  // Register indexes on the config port
  localparam logic [CfgIdxW-1:0] RegKeyMapRow0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyMapRow1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyMapRow2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyMapRow3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEraseCode  = 3'd4;

  // Reset key map: "789%", "456x", "123-", "*0=+"
  localparam logic [MapW-1:0]  KeyMapRow0Rst = 32'd624506935;
  localparam logic [MapW-1:0]  KeyMapRow1Rst = 32'd2016818484;
  localparam logic [MapW-1:0]  KeyMapRow2Rst = 32'd758329905;
  localparam logic [MapW-1:0]  KeyMapRow3Rst = 32'd725430314;
  localparam logic [CodeW-1:0] EraseCodeRst  = 8'd32;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WALK    = 2'd1,
    PH_RELEASE = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CountW-1:0]  digits_entered;
    logic [ValueW-1:0]  number_value;
    logic [ColW-1:0]    key_column;
    logic [RowW-1:0]    key_row;
    logic [CodeW-1:0]   key_code;
    logic [NumRows-1:0] row_drive;
  } out_data_t;

endpackage

// ===== rtl/keypad_scan_number_entry.sv =====
// Channel  | Dir | Beat contents (low bits first)                        | Handshake
// ---------+-----+-------------------------------------------------------+----------------
// s_axis   | in  | tdata: column_sense[3:0], zero pad to 8 bits          | tvalid/tready
// m_axis   | out | tdata: row_drive, key_code, key_row, key_column,      | tvalid/tready
//          |     |        number_value, digits_entered (56 bits)         |
//          |     | tuser: key_valid   tlast: entry_done                  |
// cfg      | in  | cfg_we_i, cfg_index_i (register 0..4), cfg_data_i     | write on we
//
// One column sample per beat, one result beat per sample; a new sample can be
// taken every cycle while m_axis is not stalled. Each sample passes an input
// register, then the scan and number update that lands in the result register.
// The divide by ten for erase is a single 32x32 reciprocal multiply.
// Reset (async, active low) returns to idle scan with all rows low, clears the
// value and digit count, and loads the default key map and erase code.
// A stalled result holds the result register; the input register still takes
// one more sample, after which s_axis_tready drops until m_axis drains.
module keypad_scan_number_entry (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [kpscan_pkg::InDataW-1:0]    s_axis_tdata,   // [3:0] column_sense

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [3:0] row_drive, [11:4] key_code, [13:12] key_row, [15:14] key_column,
  // [47:16] number_value, [55:48] digits_entered
  output logic [kpscan_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser,   // [0] key_valid
  output logic                              m_axis_tlast,   // entry_done

  input  logic                              cfg_we_i,
  input  logic [kpscan_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [kpscan_pkg::CfgDataW-1:0]   cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [kpscan_pkg::NumRows-1:0][kpscan_pkg::MapW-1:0] key_map_q;
  logic [kpscan_pkg::CodeW-1:0]                          erase_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_map_q[0] <= kpscan_pkg::KeyMapRow0Rst;
      key_map_q[1] <= kpscan_pkg::KeyMapRow1Rst;
      key_map_q[2] <= kpscan_pkg::KeyMapRow2Rst;
      key_map_q[3] <= kpscan_pkg::KeyMapRow3Rst;
      erase_code_q <= kpscan_pkg::EraseCodeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kpscan_pkg::RegKeyMapRow0: key_map_q[0] <= cfg_data_i;
        kpscan_pkg::RegKeyMapRow1: key_map_q[1] <= cfg_data_i;
        kpscan_pkg::RegKeyMapRow2: key_map_q[2] <= cfg_data_i;
        kpscan_pkg::RegKeyMapRow3: key_map_q[3] <= cfg_data_i;
        kpscan_pkg::RegEraseCode:  erase_code_q <= cfg_data_i[kpscan_pkg::CodeW-1:0];
        default: ;  // indexes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register and flow control
  // ---------------------------------------------------------------------------
  logic                              in_vld_q;
  logic [kpscan_pkg::NumCols-1:0]    cols_q;
  logic                              out_vld_q;
  logic                              advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cols_q <= s_axis_tdata[kpscan_pkg::NumCols-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Scan state
  // ---------------------------------------------------------------------------
  kpscan_pkg::phase_e                phase_q, phase_d;
  logic [kpscan_pkg::RowW-1:0]       row_q, row_d;
  logic [kpscan_pkg::ValueW-1:0]     acc_q, acc_d;
  logic [kpscan_pkg::CountW-1:0]     cnt_q, cnt_d;

  logic                              any_low;
  logic [kpscan_pkg::RowW-1:0]       row_next;

  assign any_low  = (cols_q != kpscan_pkg::AllHigh);
  assign row_next = row_q + kpscan_pkg::RowW'(1);

  // Next phase and row
  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    unique case (phase_q)
      kpscan_pkg::PH_WALK: begin
        if (any_low) begin
          phase_d = kpscan_pkg::PH_RELEASE;
        end else if (row_q == kpscan_pkg::RowW'(kpscan_pkg::NumRows - 1)) begin
          // walked every row without a hit: glitch
          phase_d = kpscan_pkg::PH_IDLE;
          row_d   = '0;
        end else begin
          row_d = row_next;
        end
      end
      kpscan_pkg::PH_RELEASE: begin
        if (!any_low) begin
          phase_d = kpscan_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_d = kpscan_pkg::PH_IDLE;
        if (any_low) begin
          phase_d = kpscan_pkg::PH_WALK;
          row_d   = '0;
        end
      end
    endcase
  end

  // Scan outputs
  logic [kpscan_pkg::NumRows-1:0]    drive;
  logic                              key_valid;
  logic [kpscan_pkg::ColW-1:0]       key_col;

  always_comb begin
    drive     = '0;
    key_valid = 1'b0;
    unique case (phase_q)
      kpscan_pkg::PH_WALK: begin
        if (any_low) begin
          key_valid = 1'b1;
        end else if (row_q != kpscan_pkg::RowW'(kpscan_pkg::NumRows - 1)) begin
          drive = ~(kpscan_pkg::NumRows'(1) << row_next);
        end
      end
      kpscan_pkg::PH_RELEASE: drive = '0;
      default: begin
        if (any_low) begin
          drive = ~kpscan_pkg::NumRows'(1);
        end
      end
    endcase
  end

  // Lowest low column
  always_comb begin
    priority if (!cols_q[0]) key_col = kpscan_pkg::ColW'(0);
    else if (!cols_q[1])     key_col = kpscan_pkg::ColW'(1);
    else if (!cols_q[2])     key_col = kpscan_pkg::ColW'(2);
    else                     key_col = kpscan_pkg::ColW'(3);
  end

  logic [kpscan_pkg::MapW-1:0]  map_row;
  logic [kpscan_pkg::CodeW-1:0] code_sel;
  logic [kpscan_pkg::CodeW-1:0] key_code;

  assign map_row  = key_map_q[row_q];
  assign code_sel = map_row[key_col*kpscan_pkg::CodeW +: kpscan_pkg::CodeW];
  assign key_code = key_valid ? code_sel : '0;

  // ---------------------------------------------------------------------------
  // Number entry
  // ---------------------------------------------------------------------------
  logic [63:0]                   div_prod;
  logic [kpscan_pkg::ValueW-1:0] acc_div10;
  logic [kpscan_pkg::ValueW-1:0] acc_mul10;
  logic                          is_erase, is_digit, done;

  assign div_prod  = {32'd0, acc_q} * {32'd0, kpscan_pkg::RecipTen};
  assign acc_div10 = kpscan_pkg::ValueW'(div_prod[63:kpscan_pkg::RecipShift]);
  assign acc_mul10 = (acc_q << 3) + (acc_q << 1)
                   + kpscan_pkg::ValueW'(code_sel - kpscan_pkg::CodeZero);

  assign is_erase = (code_sel == erase_code_q);
  assign is_digit = (code_sel >= kpscan_pkg::CodeZero) && (code_sel <= kpscan_pkg::CodeNine);

  logic [kpscan_pkg::ValueW-1:0] shown_value;
  logic [kpscan_pkg::CountW-1:0] shown_count;

  always_comb begin
    shown_value = acc_q;
    shown_count = cnt_q;
    done        = 1'b0;
    if (key_valid) begin
      priority if (is_erase) begin
        // erase wins even if the code is also a digit
        if (cnt_q != '0) begin
          shown_value = acc_div10;
          shown_count = cnt_q - kpscan_pkg::CountW'(1);
        end
      end else if (is_digit) begin
        shown_value = acc_mul10;
        if (cnt_q != kpscan_pkg::CountMax) begin
          shown_count = cnt_q + kpscan_pkg::CountW'(1);
        end
      end else begin
        done = 1'b1;
      end
    end
    acc_d = done ? '0 : shown_value;
    cnt_d = done ? '0 : shown_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kpscan_pkg::PH_IDLE;
      row_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  kpscan_pkg::out_data_t out_data_d, out_data_q;
  logic                  out_user_q, out_last_q;

  always_comb begin
    out_data_d.row_drive      = drive;
    out_data_d.key_code       = key_code;
    out_data_d.key_row        = key_valid ? row_q : '0;
    out_data_d.key_column     = key_valid ? key_col : '0;
    out_data_d.number_value   = shown_value;
    out_data_d.digits_entered = shown_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
      out_user_q <= key_valid;
      out_last_q <= done;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled while pipeline has room");

  a_key_goes_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && key_valid) |=> (phase_q == kpscan_pkg::PH_RELEASE))
    else $error("identified key did not enter release wait");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && done) |=> (acc_q == '0 && cnt_q == '0))
    else $error("entry end did not clear value and count");

  a_done_has_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && done) |-> (key_valid && drive == '0))
    else $error("entry end without an identified key");

  a_idle_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(phase_q) && $stable(acc_q) && $stable(cnt_q)))
    else $error("scan state moved without a sample");

endmodule
